// ===== rtl/core/ile_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine: list sizing,
// request and status codes, port payloads and the shifter command link.
// ----------------------------------------------------------------------------
package ile_pkg;

    // list sizing
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;
    localparam int DATA_W   = 32;

    localparam logic [DATA_W-1:0] NONE_VALUE = '1;

    // request codes
    typedef enum logic [2:0] {
        REQ_READ = 3'd0,
        REQ_HEAD = 3'd1,
        REQ_TAIL = 3'd2,
        REQ_AT   = 3'd3,
        REQ_DEL  = 3'd4
    } t_req_type;

    // status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // request payload
    typedef struct packed {
        logic        [2:0]  req_type;
        logic signed [7:0]  position;
        logic signed [31:0] item_value;
    } t_req;

    // result payload
    typedef struct packed {
        logic signed [31:0] read_value;
        logic        [1:0]  status;
        logic        [6:0]  entry_count;
    } t_result;

    // shifter operations
    typedef enum logic [1:0] {
        SHF_READ   = 2'd0,
        SHF_INSERT = 2'd1,
        SHF_DELETE = 2'd2
    } t_shf_op;

    // shifter states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_READ_DATA,
        S_UP,
        S_DOWN,
        S_DRAIN,
        S_PUT,
        S_DONE
    } t_shf_state;

    // command from control to shifter
    typedef struct packed {
        logic              valid;
        t_shf_op           op;
        logic [ADDR_W-1:0] pos;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] value;
    } t_shf_cmd;

    // response from shifter to control
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rdata;
    } t_shf_rsp;

endpackage

// ===== rtl/core/ile_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ile_shifter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_shifter
// Memory sequencer for the list: single reads, and pipelined one-entry
// shifts up (insert) or down (delete), one entry per cycle.
// ----------------------------------------------------------------------------
module ile_shifter
    import ile_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_shf_cmd i_cmd,
    output t_shf_rsp o_rsp
);

    t_shf_state        r_state, n_state;
    t_shf_op           r_op, n_op;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_end, n_end;
    logic [DATA_W-1:0] r_value, n_value;
    logic              r_wr_pend, n_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    // list storage
    ile_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // write port: delayed shift write, or the new value at the end of an insert
    assign ram_we    = r_wr_pend || (r_state == S_PUT);
    assign ram_waddr = r_wr_pend ? r_wr_addr : r_end;
    assign ram_wdata = r_wr_pend ? ram_rdata : r_value;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_pend <= n_wr_pend;
        end
        r_op      <= n_op;
        r_ptr     <= n_ptr;
        r_end     <= n_end;
        r_value   <= n_value;
        r_wr_addr <= n_wr_addr;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_value     = r_value;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        o_rsp.done  = 1'b0;
        o_rsp.rdata = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op    = i_cmd.op;
                    n_value = i_cmd.value;
                    unique case (i_cmd.op)
                        SHF_READ: begin
                            n_ptr   = i_cmd.pos;
                            n_state = S_READ;
                        end
                        SHF_INSERT: begin
                            n_end = i_cmd.pos;
                            n_ptr = ADDR_W'(i_cmd.cnt - CNT_W'(1));
                            if (CNT_W'(i_cmd.pos) == i_cmd.cnt) begin
                                n_state = S_PUT;
                            end else begin
                                n_state = S_UP;
                            end
                        end
                        SHF_DELETE: begin
                            n_ptr = i_cmd.pos + ADDR_W'(1);
                            n_end = ADDR_W'(i_cmd.cnt - CNT_W'(1));
                            if (CNT_W'(i_cmd.pos) + CNT_W'(1) == i_cmd.cnt) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_DOWN;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_READ_DATA;
            end
            S_READ_DATA: begin
                o_rsp.done = 1'b1;
                n_state    = S_IDLE;
            end
            // entry ptr moves to ptr+1, walking toward the head
            S_UP: begin
                n_wr_pend = 1'b1;
                n_wr_addr = r_ptr + ADDR_W'(1);
                if (r_ptr == r_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr - ADDR_W'(1);
                end
            end
            // entry ptr moves to ptr-1, walking toward the tail
            S_DOWN: begin
                n_wr_pend = 1'b1;
                n_wr_addr = r_ptr - ADDR_W'(1);
                if (r_ptr == r_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            // last shift write retires here
            S_DRAIN: begin
                n_state = (r_op == SHF_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                o_rsp.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/indexed_list_engine_top.sv =====
`timescale 1ns / 1ps
// A rejected or unknown request strobes its result in the cycle after the transfer.
// Reads, inserts and deletes go through the registered shifter command, the shifter
// states and the registered result; inserts and deletes shift one entry per cycle
// through the list RAM, but an append or a delete of the last entry skips the shift.
// One request at a time; the result strobe cannot be stalled by the receiver.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// indexed_list_engine_top
// Ordered list of signed 32-bit values with read, head/tail/positional
// insert and positional delete, backed by a RAM and an entry count.
// ----------------------------------------------------------------------------
module indexed_list_engine_top
    import ile_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_req    i_req,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_count, n_count;
    t_result          r_result, n_result;
    t_shf_cmd         r_cmd, n_cmd;
    t_shf_rsp         shf_rsp;

    logic             accept;
    logic             pos_neg;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] ins_pos;
    logic             list_full;
    logic [CNT_W-1:0] new_count;

    // shift sequencer and list storage
    ile_shifter u_shifter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .o_rsp   (shf_rsp)
    );

    assign accept    = i_start && !r_busy;
    assign pos_neg   = i_req.position[7];
    assign pos_ext   = CMP_W'(i_req.position[6:0]);
    assign cnt_ext   = CMP_W'(r_count);
    assign list_full = (r_count == CNT_W'(CAPACITY));

    // insert target position
    always_comb begin
        case (i_req.req_type)
            REQ_HEAD: ins_pos = '0;
            REQ_TAIL: ins_pos = cnt_ext;
            default:  ins_pos = pos_ext;
        endcase
    end

    // count after a finished shifter operation
    always_comb begin
        case (r_cmd.op)
            SHF_INSERT: new_count = r_count + CNT_W'(1);
            SHF_DELETE: new_count = r_count - CNT_W'(1);
            default:    new_count = r_count;
        endcase
    end

    // request decode and result formation
    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_count   = r_count;
        n_result  = r_result;
        n_cmd     = r_cmd;
        n_cmd.valid = 1'b0;

        if (accept) begin
            n_result.read_value  = NONE_VALUE;
            n_result.status      = ST_DONE;
            n_result.entry_count = 7'(r_count);
            n_cmd.pos            = ADDR_W'(pos_ext);
            n_cmd.cnt            = r_count;
            n_cmd.value          = i_req.item_value;
            unique case (i_req.req_type)
                REQ_READ: begin
                    if (pos_neg || pos_ext >= cnt_ext) begin
                        n_result.status = ST_RANGE;
                        n_done          = 1'b1;
                    end else begin
                        n_cmd.valid = 1'b1;
                        n_cmd.op    = SHF_READ;
                        n_busy      = 1'b1;
                    end
                end
                REQ_HEAD, REQ_TAIL, REQ_AT: begin
                    if ((i_req.req_type == REQ_AT && pos_neg) || ins_pos > cnt_ext) begin
                        n_result.status = ST_RANGE;
                        n_done          = 1'b1;
                    end else if (list_full) begin
                        n_result.status = ST_FULL;
                        n_done          = 1'b1;
                    end else begin
                        n_cmd.valid = 1'b1;
                        n_cmd.op    = SHF_INSERT;
                        n_cmd.pos   = ADDR_W'(ins_pos);
                        n_busy      = 1'b1;
                    end
                end
                REQ_DEL: begin
                    if (pos_neg || pos_ext >= cnt_ext) begin
                        n_result.status = ST_RANGE;
                        n_done          = 1'b1;
                    end else begin
                        n_cmd.valid = 1'b1;
                        n_cmd.op    = SHF_DELETE;
                        n_busy      = 1'b1;
                    end
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end

        if (shf_rsp.done) begin
            n_busy               = 1'b0;
            n_done               = 1'b1;
            n_count              = new_count;
            n_result.status      = ST_DONE;
            n_result.entry_count = 7'(new_count);
            n_result.read_value  = (r_cmd.op == SHF_READ) ? shf_rsp.rdata : NONE_VALUE;
        end
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_cmd.valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_done      <= n_done;
            r_count     <= n_count;
            r_cmd.valid <= n_cmd.valid;
        end
        r_result    <= n_result;
        r_cmd.op    <= n_cmd.op;
        r_cmd.pos   <= n_cmd.pos;
        r_cmd.cnt   <= n_cmd.cnt;
        r_cmd.value <= n_cmd.value;
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // count stays within capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    // shifter only finishes work that control handed over
    a_rsp_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shf_rsp.done |-> r_busy)
        else $error("shifter response without pending request");

    // a full refusal reports a full list
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    // a shifter command goes out only on a transfer
    a_cmd_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.valid |-> ($past(i_start) && !$past(r_busy) && r_busy))
        else $error("shifter command without transfer");

endmodule

// ===== verif/indexed_list_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_top_tb
// Self-checking bench for the indexed list engine. A queue of requests feeds
// a clocked driver. A clocked monitor predicts each transfer against a shadow
// list and compares every result strobe with the oldest prediction. Directed
// edge cases come first. Random fill, drain and mixed bursts follow, under
// three sender pacing phases.
// ----------------------------------------------------------------------------
module indexed_list_engine_top_tb;
    import ile_pkg::*;

    // request codes the engine ignores
    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = CAPACITY + 20;
    localparam int MAX_REPORTS = 10;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_req    i_req   = '0;
    logic    o_busy;
    logic    o_done;
    t_result o_result;

    // stimulus and prediction stores
    t_req        pending_reqs[$];
    t_result     expected_results[$];
    logic [31:0] shadow_list[CAPACITY];
    int          shadow_len = 0;
    int          plan_len   = 0;

    int  send_idle_pct = 12;
    bit  xfer_seen     = 1'b0;
    int  stall_cycles  = 0;
    int  n_xfers       = 0;
    int  n_results     = 0;
    int  n_mismatch    = 0;
    int  n_full        = 0;
    int  n_range       = 0;
    int  peak_len      = 0;

    indexed_list_engine_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // insert v before position p in the shadow list
    function automatic logic [1:0] shadow_insert(input int p, input logic [31:0] v);
        if (p > shadow_len) return ST_RANGE;
        if (shadow_len >= CAPACITY) return ST_FULL;
        for (int i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[p] = v;
        shadow_len++;
        return ST_DONE;
    endfunction

    // expected result of one request, updating the shadow list
    function automatic t_result predict_list_result(input t_req r);
        t_result res;
        int      p;
        p = $signed(r.position);
        res.read_value = NONE_VALUE;
        res.status     = ST_DONE;
        case (r.req_type)
            REQ_READ: begin
                if (p < 0 || p >= shadow_len) res.status = ST_RANGE;
                else res.read_value = shadow_list[p];
            end
            REQ_HEAD: res.status = shadow_insert(0, r.item_value);
            REQ_TAIL: res.status = shadow_insert(shadow_len, r.item_value);
            REQ_AT: begin
                if (p < 0) res.status = ST_RANGE;
                else res.status = shadow_insert(p, r.item_value);
            end
            REQ_DEL: begin
                if (p < 0 || p >= shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            default: ;
        endcase
        res.entry_count = shadow_len[6:0];
        return res;
    endfunction

    // queue one request and track the list length it leaves behind
    task automatic queue_request(input logic [2:0] kind, input int pos,
                                 input logic [31:0] value);
        t_req r;
        r.req_type   = kind;
        r.position   = pos[7:0];
        r.item_value = value;
        pending_reqs.push_back(r);
        case (kind)
            REQ_HEAD, REQ_TAIL: if (plan_len < CAPACITY) plan_len++;
            REQ_AT: if (pos >= 0 && pos <= plan_len && plan_len < CAPACITY) plan_len++;
            REQ_DEL: if (pos >= 0 && pos < plan_len) plan_len--;
            default: ;
        endcase
    endtask

    // one random request with the given insert and delete weights
    task automatic queue_random(input int ins_w, input int del_w);
        int          pick;
        int          pos;
        logic [2:0]  kind;
        logic [31:0] value;
        pick = $urandom_range(99);
        if (pick < ins_w) begin
            case ($urandom_range(2))
                0: kind = REQ_HEAD;
                1: kind = REQ_TAIL;
                default: kind = REQ_AT;
            endcase
        end else if (pick < ins_w + del_w) begin
            kind = REQ_DEL;
        end else if (pick < 99) begin
            kind = REQ_READ;
        end else begin
            kind = 3'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
        end
        // positions mostly near the live list, some negative or far out
        case ($urandom_range(9))
            0: pos = -int'($urandom_range(128, 1));
            1: pos = $urandom_range(127);
            2: pos = plan_len - int'($urandom_range(1));
            default: pos = $urandom_range(plan_len);
        endcase
        case ($urandom_range(15))
            0: value = 32'h8000_0000;
            1: value = 32'h7fff_ffff;
            2: value = '1;
            default: value = $urandom;
        endcase
        queue_request(kind, pos, value);
    endtask

    // random bursts that each fill, drain or churn the list
    task automatic queue_bursts(input int total);
        int left;
        int n;
        int ins_w;
        int del_w;
        left = total;
        while (left > 0) begin
            n = $urandom_range(60, 30);
            if (n > left) n = left;
            case ($urandom_range(2))
                0: begin ins_w = 70; del_w = 10; end
                1: begin ins_w = 10; del_w = 70; end
                default: begin ins_w = 35; del_w = 35; end
            endcase
            repeat (n) queue_random(ins_w, del_w);
            left -= n;
        end
    endtask

    task automatic wait_queue_empty();
        while (pending_reqs.size() != 0 || i_start) @(posedge i_clk);
    endtask

    // driver: present the head of the queue, hold it until the transfer
    always @(negedge i_clk) begin
        logic offer;
        offer = 1'b0;
        if (xfer_seen) begin
            void'(pending_reqs.pop_front());
            xfer_seen = 1'b0;
            if (i_rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                offer = 1'b1;
        end else if (i_start) begin
            offer = 1'b1;
        end else if (i_rst_n && pending_reqs.size() > 0
                     && $urandom_range(99) >= send_idle_pct) begin
            offer = 1'b1;
        end
        i_start <= offer;
        if (offer) i_req <= pending_reqs[0];
    end

    // monitor: check result strobes, then predict new transfers
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            n_results++;
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("unexpected result: value %0d status %0d count %0d",
                             $signed(o_result.read_value), o_result.status,
                             o_result.entry_count);
            end else begin
                want = expected_results.pop_front();
                if (o_result.read_value !== want.read_value
                    || o_result.status !== want.status
                    || o_result.entry_count !== want.entry_count) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display({"result %0d mismatch: expected value %0d status %0d ",
                                  "count %0d, got value %0d status %0d count %0d"},
                                 n_results, $signed(want.read_value), want.status,
                                 want.entry_count, $signed(o_result.read_value),
                                 o_result.status, o_result.entry_count);
                end
            end
        end
        if (i_rst_n && i_start && !o_busy) begin
            want = predict_list_result(i_req);
            expected_results.push_back(want);
            n_xfers++;
            if (want.status == ST_FULL) n_full++;
            if (want.status == ST_RANGE) n_range++;
            if (shadow_len > peak_len) peak_len = shadow_len;
            xfer_seen = 1'b1;
        end
    end

    // watchdog on cycles with no transfer and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("[indexed_list_engine_top] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extremes, edges of every request
        queue_request(REQ_READ, 0, 32'h0);
        queue_request(REQ_DEL, 0, 32'h0);
        queue_request(REQ_AT, 1, 32'hdead_beef);
        queue_request(REQ_AT, 0, 32'h1234_5678);
        queue_request(REQ_HEAD, 0, 32'h8000_0000);
        queue_request(REQ_TAIL, 0, 32'h7fff_ffff);
        queue_request(REQ_AT, 1, 32'hffff_ffff);
        queue_request(REQ_AT, 4, 32'h55aa_55aa);
        queue_request(REQ_AT, 6, 32'h0bad_0bad);
        queue_request(REQ_AT, -1, 32'h0bad_0bad);
        queue_request(REQ_READ, 0, 32'h0);
        queue_request(REQ_READ, 4, 32'h0);
        queue_request(REQ_READ, 5, 32'h0);
        queue_request(REQ_READ, -128, 32'h0);
        queue_request(REQ_READ, 127, 32'h0);
        queue_request(REQ_DEL, 127, 32'h0);
        queue_request(REQ_DEL, -1, 32'h0);
        queue_request(REQ_DEL, 4, 32'h0);
        queue_request(REQ_DEL, 0, 32'h0);
        queue_request(REQ_DEL, 1, 32'h0);
        queue_request(REQ_READ, 1, 32'h0);
        queue_request(REQ_UNKNOWN_LO, 0, 32'hffff_ffff);
        queue_request(REQ_UNKNOWN_HI, -128, 32'h8000_0000);
        queue_request(REQ_READ, 0, 32'h0);

        // fill well past capacity so full refusals show up, then mix
        repeat (100) queue_random(90, 3);
        queue_bursts(125);
        wait_queue_empty();

        send_idle_pct = 75;
        queue_bursts(250);
        wait_queue_empty();

        send_idle_pct = 0;
        queue_bursts(250);
        wait_queue_empty();

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d requests, %0d results, %0d mismatches", n_xfers, n_results, n_mismatch);
        $display("list peaked at %0d entries; %0d full refusals, %0d out-of-range requests",
                 peak_len, n_full, n_range);
        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("[indexed_list_engine_top] OK");
        else
            $display("[indexed_list_engine_top] ERROR");
        $finish;
    end

endmodule

// ===== indexed_list_engine_top.f =====
rtl/core/ile_pkg.sv
rtl/core/ile_ram.sv
rtl/core/ile_shifter.sv
rtl/core/indexed_list_engine_top.sv
verif/indexed_list_engine_top_tb.sv
